### hw/rtl/i2cms_pkg.sv
// Shared types and constants for the I2C master byte sequencer.
// No dependencies; used by i2cms_core and i2c_master_byte_sequencer.

package i2cms_pkg;

  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 16;

  localparam logic [CFG_W-1:0] HALF_BIT_RST = 12'd5;
  localparam logic [CFG_W-1:0] SETUP_RST    = 12'd2;
  localparam logic [7:0]       MSB_MASK     = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_BIT = 2'd0,
    REG_SETUP    = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_ST_A      = 4'd1,
    PH_ST_B      = 4'd2,
    PH_ST_C      = 4'd3,
    PH_SP_A      = 4'd4,
    PH_SP_B      = 4'd5,
    PH_SP_C      = 4'd6,
    PH_WR_SETUP  = 4'd7,
    PH_WR_HIGH   = 4'd8,
    PH_WR_LOW    = 4'd9,
    PH_WR_ACK    = 4'd10,
    PH_RD_HIGH   = 4'd11,
    PH_RD_LOW    = 4'd12,
    PH_RD_ASETUP = 4'd13,
    PH_RD_AHIGH  = 4'd14,
    PH_RD_ALOW   = 4'd15
  } phase_e;

  typedef struct packed {
    logic       sda_in;
    logic       send_ack;
    logic [7:0] tx_byte;
    opcode_e    opcode;
    logic       cmd_valid;
  } item_t;

  typedef struct packed {
    logic       ack_level;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } result_t;

endpackage

### hw/rtl/i2cms_core.sv
// Tick step logic and bus state of the I2C master byte sequencer.
// Depends on i2cms_pkg.

module i2cms_core #(
  parameter int DELAY_WIDTH = 12
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  i2cms_pkg::item_t             item_i,
  input  logic [i2cms_pkg::CFG_W-1:0]  half_bit_i,
  input  logic [i2cms_pkg::CFG_W-1:0]  setup_i,
  output i2cms_pkg::result_t           res_o
);

  localparam int ExtW = ((DELAY_WIDTH > i2cms_pkg::CFG_W) ? DELAY_WIDTH : i2cms_pkg::CFG_W) + 1;
  localparam logic [ExtW-1:0] DelayMax = ExtW'((64'd1 << DELAY_WIDTH) - 64'd1);

  // zero counts as one tick, too large saturates
  function automatic logic [DELAY_WIDTH-1:0] ticks_of(input logic [i2cms_pkg::CFG_W-1:0] v);
    logic [ExtW-1:0] ext;
    ext = ExtW'(v);
    if (v == '0) ext = ExtW'(1);
    if (ext > DelayMax) ext = DelayMax;
    return ext[DELAY_WIDTH-1:0];
  endfunction

  i2cms_pkg::phase_e      phase_q, phase_d;
  logic [3:0]             bit_cnt_q, bit_cnt_d;
  logic [7:0]             shift_q, shift_d;
  logic [DELAY_WIDTH-1:0] delay_q, delay_d;
  logic                   ack_req_q, ack_req_d;
  logic                   scl_q, scl_d;
  logic                   sda_q, sda_d;
  logic                   ack_seen_q, ack_seen_d;
  logic [7:0]             rx_q, rx_d;
  logic                   done;
  logic [DELAY_WIDTH-1:0] half_t, setup_t;
  logic [3:0]             bit_inc;
  logic [7:0]             shift_nx;

  assign half_t   = ticks_of(half_bit_i);
  assign setup_t  = ticks_of(setup_i);
  assign bit_inc  = bit_cnt_q + 4'd1;
  assign shift_nx = {shift_q[6:0], 1'b0};

  always_comb begin
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    delay_d    = delay_q;
    ack_req_d  = ack_req_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    ack_seen_d = ack_seen_q;
    rx_d       = rx_q;
    done       = 1'b0;

    if (phase_q == i2cms_pkg::PH_IDLE) begin
      if (item_i.cmd_valid) begin
        unique case (item_i.opcode)
          i2cms_pkg::OP_START: begin
            scl_d = 1'b1; sda_d = 1'b1;
            phase_d = i2cms_pkg::PH_ST_A; delay_d = half_t;
          end
          i2cms_pkg::OP_STOP: begin
            scl_d = 1'b0; sda_d = 1'b0;
            phase_d = i2cms_pkg::PH_SP_A; delay_d = half_t;
          end
          i2cms_pkg::OP_WRITE: begin
            shift_d = item_i.tx_byte; bit_cnt_d = '0;
            sda_d = |(item_i.tx_byte & i2cms_pkg::MSB_MASK);
            phase_d = i2cms_pkg::PH_WR_SETUP; delay_d = setup_t;
          end
          default: begin
            shift_d = '0; bit_cnt_d = '0; ack_req_d = item_i.send_ack;
            sda_d = 1'b1; scl_d = 1'b1;
            phase_d = i2cms_pkg::PH_RD_HIGH; delay_d = half_t;
          end
        endcase
      end
    end else if (delay_q > DELAY_WIDTH'(1)) begin
      delay_d = delay_q - DELAY_WIDTH'(1);
    end else begin
      unique case (phase_q)
        i2cms_pkg::PH_ST_A: begin
          sda_d = 1'b0; phase_d = i2cms_pkg::PH_ST_B; delay_d = half_t;
        end
        i2cms_pkg::PH_ST_B: begin
          scl_d = 1'b0; phase_d = i2cms_pkg::PH_ST_C; delay_d = half_t;
        end
        i2cms_pkg::PH_SP_A: begin
          scl_d = 1'b1; phase_d = i2cms_pkg::PH_SP_B; delay_d = half_t;
        end
        i2cms_pkg::PH_SP_B: begin
          sda_d = 1'b1; phase_d = i2cms_pkg::PH_SP_C; delay_d = half_t;
        end
        i2cms_pkg::PH_WR_SETUP: begin
          scl_d = 1'b1; phase_d = i2cms_pkg::PH_WR_HIGH; delay_d = half_t;
        end
        i2cms_pkg::PH_WR_HIGH: begin
          scl_d = 1'b0; phase_d = i2cms_pkg::PH_WR_LOW; delay_d = setup_t;
        end
        i2cms_pkg::PH_WR_LOW: begin
          bit_cnt_d = bit_inc;
          if (bit_inc < 4'd8) begin
            shift_d = shift_nx;
            sda_d   = |(shift_nx & i2cms_pkg::MSB_MASK);
            phase_d = i2cms_pkg::PH_WR_SETUP; delay_d = setup_t;
          end else begin
            sda_d = 1'b1; scl_d = 1'b1;
            phase_d = i2cms_pkg::PH_WR_ACK; delay_d = half_t;
          end
        end
        i2cms_pkg::PH_WR_ACK: begin
          ack_seen_d = item_i.sda_in; scl_d = 1'b0;
          done = 1'b1;
        end
        i2cms_pkg::PH_RD_HIGH: begin
          shift_d = {shift_q[6:0], item_i.sda_in};
          scl_d = 1'b0; phase_d = i2cms_pkg::PH_RD_LOW; delay_d = half_t;
        end
        i2cms_pkg::PH_RD_LOW: begin
          bit_cnt_d = bit_inc;
          if (bit_inc < 4'd8) begin
            scl_d = 1'b1; phase_d = i2cms_pkg::PH_RD_HIGH; delay_d = half_t;
          end else begin
            if (ack_req_q) sda_d = 1'b0;
            phase_d = i2cms_pkg::PH_RD_ASETUP; delay_d = setup_t;
          end
        end
        i2cms_pkg::PH_RD_ASETUP: begin
          scl_d = 1'b1; phase_d = i2cms_pkg::PH_RD_AHIGH; delay_d = half_t;
        end
        i2cms_pkg::PH_RD_AHIGH: begin
          scl_d = 1'b0; phase_d = i2cms_pkg::PH_RD_ALOW; delay_d = half_t;
        end
        i2cms_pkg::PH_RD_ALOW: begin
          rx_d = shift_q;
          done = 1'b1;
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        phase_d = i2cms_pkg::PH_IDLE;
        delay_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= i2cms_pkg::PH_IDLE;
      bit_cnt_q  <= '0;
      shift_q    <= '0;
      delay_q    <= '0;
      ack_req_q  <= 1'b0;
      scl_q      <= 1'b1;
      sda_q      <= 1'b1;
      ack_seen_q <= 1'b1;
      rx_q       <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      bit_cnt_q  <= bit_cnt_d;
      shift_q    <= shift_d;
      delay_q    <= delay_d;
      ack_req_q  <= ack_req_d;
      scl_q      <= scl_d;
      sda_q      <= sda_d;
      ack_seen_q <= ack_seen_d;
      rx_q       <= rx_d;
    end
  end

  always_comb begin
    res_o.scl_out   = scl_d;
    res_o.sda_out   = sda_d;
    res_o.busy_res  = (phase_d != i2cms_pkg::PH_IDLE);
    res_o.done_res  = done;
    res_o.rx_byte   = rx_d;
    res_o.ack_level = ack_seen_d;
  end

endmodule

### hw/rtl/i2c_master_byte_sequencer.sv
// An accepted tick goes through the input register and then the result register to the output.
// One tick per clock unless results stall; the step logic between the registers is single pass.
// The output register decouples the sides: an empty input stage takes a tick while a result waits.
// Reset (rst_ni low, async): bus released (SCL/SDA high), sequencer idle, ack_level 1,
// rx_byte 0, half_bit_ticks 5, setup_ticks 2. No clearing pass; ready right after reset.
// Depends on i2cms_pkg and i2cms_core.

module i2c_master_byte_sequencer #(
  parameter int DELAY_WIDTH = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // tick input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [0] cmd_valid, [2:1] opcode, [10:3] tx_byte, [11] send_ack, [12] sda_in, [15:13] zero
  input  logic [i2cms_pkg::IN_W-1:0]       s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] rx_byte, [12] ack_level,
  // [15:13] zero
  output logic [i2cms_pkg::OUT_W-1:0]      m_axis_tdata,
  // register writes: index 0 half_bit_ticks, index 1 setup_ticks
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [i2cms_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [i2cms_pkg::CFG_W-1:0]      cfg_data_i
);

  // Config registers; writes to unknown indexes are dropped.
  logic [i2cms_pkg::CFG_W-1:0] half_bit_q, setup_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_bit_q <= i2cms_pkg::HALF_BIT_RST;
      setup_q    <= i2cms_pkg::SETUP_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        i2cms_pkg::REG_HALF_BIT: half_bit_q <= cfg_data_i;
        i2cms_pkg::REG_SETUP:    setup_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register stage.
  logic             in_valid_q;
  i2cms_pkg::item_t in_item_q;
  logic             step_en;
  logic             in_take;

  // Step fires when a tick is held and the result register is free (or draining).
  assign step_en       = in_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step_en;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_item_q.cmd_valid <= s_axis_tdata[0];
      in_item_q.opcode    <= i2cms_pkg::opcode_e'(s_axis_tdata[2:1]);
      in_item_q.tx_byte   <= s_axis_tdata[10:3];
      in_item_q.send_ack  <= s_axis_tdata[11];
      in_item_q.sda_in    <= s_axis_tdata[12];
    end
  end

  // Sequencer: state advances exactly once per tick, when its result is captured.
  i2cms_pkg::result_t res;

  i2cms_core #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step_en),
    .item_i     (in_item_q),
    .half_bit_i (half_bit_q),
    .setup_i    (setup_q),
    .res_o      (res)
  );

  // Result register.
  logic               out_valid_q;
  i2cms_pkg::result_t out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_en) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_res_q.ack_level, out_res_q.rx_byte,
                          out_res_q.done_res, out_res_q.busy_res,
                          out_res_q.sda_out, out_res_q.scl_out};

`ifndef SYNTHESIS
  // A completing tick never reports the sequencer as still busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en && res.done_res |-> !res.busy_res)
    else $error("done and busy both set");

  // A stalled result blocks the step, so the bus state cannot run ahead.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !step_en)
    else $error("step while result stalled");

  // A held tick that is not stepped stays held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !step_en |=> in_valid_q && $stable(in_item_q))
    else $error("held tick lost");

  // Every step produces a pending result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_en |=> out_valid_q)
    else $error("step result dropped");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the I2C master byte sequencer (one bus tick per transaction).
// Drives tick transactions, predicts every result tick and compares field by field.
// Depends on i2cms_pkg and the i2c_master_byte_sequencer RTL.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DELAY_W     = 12;
  localparam int RAND_TICKS  = 900;
  localparam int HOLD_LEN    = 300;   // long receiver hold-off, forces input backpressure
  localparam int STALL_LIMIT = 3000;  // cycles with no transaction anywhere
  localparam int MAX_SHOWN   = 10;

  // register indexes with no register behind them; writes there are dropped
  localparam logic [i2cms_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [i2cms_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // how the SDA line is sampled on busy ticks
  localparam int SDA_LOW  = 0;
  localparam int SDA_HIGH = 1;
  localparam int SDA_RAND = 2;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [i2cms_pkg::IN_W-1:0]      s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [i2cms_pkg::OUT_W-1:0]     m_axis_tdata;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [i2cms_pkg::CFG_IDX_W-1:0] cfg_addr_i = '0;
  logic [i2cms_pkg::CFG_W-1:0]     cfg_data_i = '0;

  i2c_master_byte_sequencer #(.DELAY_WIDTH(DELAY_W)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Bus sequencer prediction: own copy of registers and sequencer state
  // ---------------------------------------------------------------------------
  logic [i2cms_pkg::CFG_W-1:0] half_q     = i2cms_pkg::HALF_BIT_RST;
  logic [i2cms_pkg::CFG_W-1:0] setup_q    = i2cms_pkg::SETUP_RST;
  i2cms_pkg::phase_e           bus_phase  = i2cms_pkg::PH_IDLE;
  logic [3:0]                  bit_idx    = '0;
  logic [7:0]                  shift_q    = '0;
  logic [DELAY_W-1:0]          dly_left   = '0;
  logic                        ack_req_q  = 1'b0;
  logic                        scl_q      = 1'b1;
  logic                        sda_q      = 1'b1;
  logic                        ack_seen_q = 1'b1;
  logic [7:0]                  rx_last    = '0;

  i2cms_pkg::result_t bus_outcome_q[$];  // predicted result ticks, oldest first

  int  n_ticks, n_results, n_errors, n_done, n_cfg;
  int  n_cmds[4];
  bit  tx_steady, rx_steady;
  int  hold_len_req;
  int  quiet_cycles;

  function automatic void enter_phase(i2cms_pkg::phase_e p, logic [i2cms_pkg::CFG_W-1:0] n);
    bus_phase = p;
    dly_left  = (n == '0) ? DELAY_W'(1) : DELAY_W'(n);  // zero counts as one tick
  endfunction

  function automatic i2cms_pkg::result_t tick_outcome(i2cms_pkg::item_t it);
    i2cms_pkg::result_t r;
    logic               finished;
    finished = 1'b0;
    if (bus_phase == i2cms_pkg::PH_IDLE) begin
      if (it.cmd_valid) begin
        n_cmds[it.opcode]++;
        case (it.opcode)
          i2cms_pkg::OP_START: begin
            scl_q = 1'b1;
            sda_q = 1'b1;
            enter_phase(i2cms_pkg::PH_ST_A, half_q);
          end
          i2cms_pkg::OP_STOP: begin
            sda_q = 1'b0;
            scl_q = 1'b0;
            enter_phase(i2cms_pkg::PH_SP_A, half_q);
          end
          i2cms_pkg::OP_WRITE: begin
            shift_q = it.tx_byte;
            bit_idx = '0;
            sda_q   = (shift_q & i2cms_pkg::MSB_MASK) != '0;
            enter_phase(i2cms_pkg::PH_WR_SETUP, setup_q);
          end
          default: begin
            // read: SDA released together with the first SCL rise
            shift_q   = '0;
            bit_idx   = '0;
            ack_req_q = it.send_ack;
            sda_q     = 1'b1;
            scl_q     = 1'b1;
            enter_phase(i2cms_pkg::PH_RD_HIGH, half_q);
          end
        endcase
      end
    end else if (dly_left > 1) begin
      dly_left = dly_left - 1'b1;
    end else begin
      case (bus_phase)
        i2cms_pkg::PH_ST_A: begin
          sda_q = 1'b0;
          enter_phase(i2cms_pkg::PH_ST_B, half_q);
        end
        i2cms_pkg::PH_ST_B: begin
          scl_q = 1'b0;
          enter_phase(i2cms_pkg::PH_ST_C, half_q);
        end
        i2cms_pkg::PH_SP_A: begin
          scl_q = 1'b1;
          enter_phase(i2cms_pkg::PH_SP_B, half_q);
        end
        i2cms_pkg::PH_SP_B: begin
          sda_q = 1'b1;
          enter_phase(i2cms_pkg::PH_SP_C, half_q);
        end
        i2cms_pkg::PH_WR_SETUP: begin
          scl_q = 1'b1;
          enter_phase(i2cms_pkg::PH_WR_HIGH, half_q);
        end
        i2cms_pkg::PH_WR_HIGH: begin
          scl_q = 1'b0;
          enter_phase(i2cms_pkg::PH_WR_LOW, setup_q);
        end
        i2cms_pkg::PH_WR_LOW: begin
          bit_idx = bit_idx + 1'b1;
          if (bit_idx < 8) begin
            shift_q = shift_q << 1;
            sda_q   = (shift_q & i2cms_pkg::MSB_MASK) != '0;
            enter_phase(i2cms_pkg::PH_WR_SETUP, setup_q);
          end else begin
            // release SDA for the slave's acknowledge
            sda_q = 1'b1;
            scl_q = 1'b1;
            enter_phase(i2cms_pkg::PH_WR_ACK, half_q);
          end
        end
        i2cms_pkg::PH_WR_ACK: begin
          ack_seen_q = it.sda_in;
          scl_q      = 1'b0;
          finished   = 1'b1;
        end
        i2cms_pkg::PH_RD_HIGH: begin
          shift_q = {shift_q[6:0], it.sda_in};
          scl_q   = 1'b0;
          enter_phase(i2cms_pkg::PH_RD_LOW, half_q);
        end
        i2cms_pkg::PH_RD_LOW: begin
          bit_idx = bit_idx + 1'b1;
          if (bit_idx < 8) begin
            scl_q = 1'b1;
            enter_phase(i2cms_pkg::PH_RD_HIGH, half_q);
          end else begin
            if (ack_req_q) sda_q = 1'b0;
            enter_phase(i2cms_pkg::PH_RD_ASETUP, setup_q);
          end
        end
        i2cms_pkg::PH_RD_ASETUP: begin
          scl_q = 1'b1;
          enter_phase(i2cms_pkg::PH_RD_AHIGH, half_q);
        end
        i2cms_pkg::PH_RD_AHIGH: begin
          scl_q = 1'b0;
          enter_phase(i2cms_pkg::PH_RD_ALOW, half_q);
        end
        i2cms_pkg::PH_RD_ALOW: begin
          rx_last  = shift_q;
          finished = 1'b1;
        end
        default: finished = 1'b1;  // end of start or stop condition
      endcase
      if (finished) begin
        bus_phase = i2cms_pkg::PH_IDLE;
        dly_left  = '0;
        n_done++;
      end
    end
    r.scl_out   = scl_q;
    r.sda_out   = sda_q;
    r.busy_res  = (bus_phase != i2cms_pkg::PH_IDLE);
    r.done_res  = finished;
    r.rx_byte   = rx_last;
    r.ack_level = ack_seen_q;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // mostly back to back, sometimes a few cycles, rarely a long gap
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic line_level(int sda_mode);
    case (sda_mode)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      default:  return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // tick with random content; any command on it is ignored while busy
  function automatic i2cms_pkg::item_t busy_tick(int sda_mode);
    i2cms_pkg::item_t it;
    it.cmd_valid = 1'($urandom_range(0, 1));
    it.opcode    = i2cms_pkg::opcode_e'(2'($urandom_range(0, 3)));
    it.tx_byte   = 8'($urandom);
    it.send_ack  = 1'($urandom_range(0, 1));
    it.sda_in    = line_level(sda_mode);
    return it;
  endfunction

  function automatic i2cms_pkg::item_t quiet_tick();
    i2cms_pkg::item_t it;
    it = busy_tick(SDA_RAND);
    it.cmd_valid = 1'b0;
    return it;
  endfunction

  // tvalid stays high after the transaction unless a gap follows
  task automatic send_tick(i2cms_pkg::item_t it);
    int gap;
    cfg_valid_i   <= 1'b0;
    s_axis_tdata  <= {{(i2cms_pkg::IN_W - $bits(i2cms_pkg::item_t)){1'b0}}, it};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    bus_outcome_q.push_back(tick_outcome(it));
    n_ticks++;
    gap = tx_steady ? 0 : gap_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_outcomes();
    s_axis_tvalid <= 1'b0;
    while (bus_outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // only called with the sequencer idle; waits for all result ticks first
  task automatic cfg_write(logic [i2cms_pkg::CFG_IDX_W-1:0] idx,
                           logic [i2cms_pkg::CFG_W-1:0] val);
    drain_outcomes();
    cfg_addr_i  <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    n_cfg++;
    if (idx == i2cms_pkg::REG_HALF_BIT) half_q = val;
    else if (idx == i2cms_pkg::REG_SETUP) setup_q = val;
  endtask

  // offer one command on an idle tick and tick until the sequence is over
  task automatic issue(i2cms_pkg::opcode_e op, logic [7:0] tx, logic ack, int sda_mode);
    i2cms_pkg::item_t it;
    it = busy_tick(sda_mode);
    it.cmd_valid = 1'b1;
    it.opcode    = op;
    it.tx_byte   = tx;
    it.send_ack  = ack;
    send_tick(it);
    while (bus_phase != i2cms_pkg::PH_IDLE) send_tick(busy_tick(sda_mode));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // released bus, reset timing registers, idle ticks without a command
  task automatic test_reset_defaults();
    repeat (4) send_tick(quiet_tick());
    issue(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RAND);
    issue(i2cms_pkg::OP_WRITE, 8'($urandom), 1'b0, SDA_LOW);
    issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND);
  endtask

  // every command, byte extremes, ACK and NACK on both directions
  task automatic test_each_command();
    cfg_write(i2cms_pkg::REG_HALF_BIT, 12'd1);
    cfg_write(i2cms_pkg::REG_SETUP, 12'd1);
    issue(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RAND);
    issue(i2cms_pkg::OP_WRITE, 8'hFF, 1'b0, SDA_LOW);
    issue(i2cms_pkg::OP_WRITE, 8'h00, 1'b0, SDA_HIGH);
    issue(i2cms_pkg::OP_WRITE, 8'hA5, 1'b0, SDA_RAND);
    issue(i2cms_pkg::OP_READ, 8'h00, 1'b1, SDA_HIGH);
    issue(i2cms_pkg::OP_READ, 8'hFF, 1'b0, SDA_LOW);
    issue(i2cms_pkg::OP_READ, 8'h5A, 1'b1, SDA_RAND);
    issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND);
    issue(i2cms_pkg::OP_STOP, 8'h00, 1'b0, SDA_RAND);   // stop on an already idle bus
    repeat (3) send_tick(quiet_tick());
  endtask

  // zero delays, writes to unused indexes, and long delays on both registers
  task automatic test_register_edges();
    cfg_write(i2cms_pkg::REG_HALF_BIT, 12'd0);
    cfg_write(i2cms_pkg::REG_SETUP, 12'd0);
    issue(i2cms_pkg::OP_WRITE, 8'($urandom), 1'b0, SDA_RAND);
    issue(i2cms_pkg::OP_READ, 8'h00, 1'b1, SDA_RAND);
    cfg_write(REG_SPARE_A, 12'($urandom));
    cfg_write(REG_SPARE_B, 12'hFFF);
    issue(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RAND);
    cfg_write(i2cms_pkg::REG_HALF_BIT, 12'd64);
    issue(i2cms_pkg::OP_START, 8'h00, 1'b0, SDA_RAND);
    cfg_write(i2cms_pkg::REG_HALF_BIT, 12'd1);
    cfg_write(i2cms_pkg::REG_SETUP, 12'd64);
    issue(i2cms_pkg::OP_READ, 8'h00, 1'b1, SDA_RAND);
    cfg_write(i2cms_pkg::REG_SETUP, 12'd1);
  endtask

  task automatic random_timing();
    int r;
    r = $urandom_range(0, 9);
    cfg_write(i2cms_pkg::REG_HALF_BIT,
              (r < 2) ? 12'd0 : (r < 8) ? 12'($urandom_range(1, 3))
                                        : 12'($urandom_range(4, 12)));
    r = $urandom_range(0, 9);
    cfg_write(i2cms_pkg::REG_SETUP,
              (r < 2) ? 12'd0 : (r < 8) ? 12'($urandom_range(1, 3))
                                        : 12'($urandom_range(4, 12)));
  endtask

  // mostly well-formed transfers: start, address, data bytes, stop;
  // the rest are stray commands and transfers left without a stop
  task automatic test_random_transfers();
    int  base, done_ticks, nbytes;
    bit  rd, hold_done;
    base      = n_ticks;
    hold_done = 1'b0;
    while (n_ticks - base < RAND_TICKS) begin
      done_ticks = n_ticks - base;
      if ($urandom_range(0, 7) == 0) random_timing();
      // one long receiver hold-off while ticks keep coming
      if (!hold_done && done_ticks > RAND_TICKS / 3) begin
        hold_len_req = HOLD_LEN;
        hold_done    = 1'b1;
      end
      // a stretch with no gaps on either side
      tx_steady = (done_ticks > 2 * RAND_TICKS / 3) &&
                  (done_ticks < 2 * RAND_TICKS / 3 + 200);
      rx_steady = tx_steady;
      repeat ($urandom_range(0, 2)) send_tick(quiet_tick());
      if ($urandom_range(0, 99) < 85) begin
        rd = 1'($urandom_range(0, 1));
        issue(i2cms_pkg::OP_START, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND);
        issue(i2cms_pkg::OP_WRITE, {7'($urandom), rd}, 1'($urandom_range(0, 1)), SDA_RAND);
        nbytes = $urandom_range(1, 3);
        repeat (nbytes) begin
          if (rd) issue(i2cms_pkg::OP_READ, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND);
          else issue(i2cms_pkg::OP_WRITE, 8'($urandom), 1'($urandom_range(0, 1)), SDA_RAND);
        end
        if ($urandom_range(0, 4) != 0)
          issue(i2cms_pkg::OP_STOP, 8'($urandom), 1'b0, SDA_RAND);
      end else begin
        repeat ($urandom_range(1, 4))
          issue(i2cms_pkg::opcode_e'(2'($urandom_range(0, 3))), 8'($urandom),
                1'($urandom_range(0, 1)), SDA_RAND);
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, the long hold-off, checking, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (hold_len_req != 0) begin
        stall        = hold_len_req;
        hold_len_req = 0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = ($urandom_range(0, 99) < 35) ? gap_len() : 0;
      end
      if (stall == 0) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    i2cms_pkg::result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = i2cms_pkg::result_t'(m_axis_tdata[$bits(i2cms_pkg::result_t)-1:0]);
      n_results++;
      if (bus_outcome_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("result %0d: nothing expected, got %h", n_results, got);
      end else begin
        want = bus_outcome_q.pop_front();
        if (got.scl_out !== want.scl_out || got.sda_out !== want.sda_out ||
            got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
            got.rx_byte !== want.rx_byte || got.ack_level !== want.ack_level) begin
          n_errors++;
          if (n_errors <= MAX_SHOWN) begin
            $display("result %0d: want scl %b sda %b busy %b done %b rx %h ack %b",
                     n_results, want.scl_out, want.sda_out, want.busy_res,
                     want.done_res, want.rx_byte, want.ack_level);
            $display("            got  scl %b sda %b busy %b done %b rx %h ack %b",
                     got.scl_out, got.sda_out, got.busy_res, got.done_res,
                     got.rx_byte, got.ack_level);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, bus_outcome_q.size());
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_each_command();
    test_register_edges();
    test_random_transfers();
    drain_outcomes();
    repeat (8) @(posedge clk_i);
    $display("run covered %0d ticks: %0d start, %0d stop, %0d write, %0d read, %0d completed",
             n_ticks, n_cmds[i2cms_pkg::OP_START], n_cmds[i2cms_pkg::OP_STOP],
             n_cmds[i2cms_pkg::OP_WRITE], n_cmds[i2cms_pkg::OP_READ], n_done);
    $display("%0d register writes, %0d results checked, %0d mismatches",
             n_cfg, n_results, n_errors);
    if (n_errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
